// ===== rtl/core/htg_pkg.sv =====
// ----------------------------------------------------------------------------
// htg_pkg
// Types and constants shared by the hierarchical tile geometry block.
// ----------------------------------------------------------------------------
package htg_pkg;

  localparam int LEVELS_DEF   = 3;
  localparam int FIELD_LEVELS = 3;
  localparam int EXT_W        = 31;
  localparam int CNT_W        = 16;
  localparam int PROD_W       = EXT_W + CNT_W;
  // mult stage, one stage per quotient bit, finalize stage
  localparam int LVL_STAGES   = EXT_W + 2;

  typedef logic [EXT_W-1:0] ext_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic                          bad;
    logic [1:0]                    used;
    ext_t                          cur;
    ext_t                          offset;
    logic [FIELD_LEVELS-1:0][CNT_W-1:0] cnt;
    logic [FIELD_LEVELS-1:0][CNT_W-1:0] idx;
    cnt_t                          rem_a;
    cnt_t                          rem_b;
    ext_t                          dvd_a;
    ext_t                          dvd_b;
    ext_t                          quo_a;
    ext_t                          quo_b;
  } pipe_t;

endpackage

// ===== rtl/core/htg_in_if.sv =====
// ----------------------------------------------------------------------------
// htg_in_if
// Input channel: one array dimension with its tiling per level.
// ----------------------------------------------------------------------------
interface htg_in_if;
  import htg_pkg::*;

  logic valid;
  logic ready;
  ext_t extent;
  cnt_t tiles_level0;
  cnt_t tiles_level1;
  cnt_t tiles_level2;
  cnt_t index_level0;
  cnt_t index_level1;
  cnt_t index_level2;

  modport source (output valid, extent, tiles_level0, tiles_level1, tiles_level2,
                  index_level0, index_level1, index_level2, input ready);
  modport sink (input valid, extent, tiles_level0, tiles_level1, tiles_level2,
                index_level0, index_level1, index_level2, output ready);
endinterface

// ===== rtl/core/htg_out_if.sv =====
// ----------------------------------------------------------------------------
// htg_out_if
// Result channel: leaf tile offset, length and error flag.
// ----------------------------------------------------------------------------
interface htg_out_if;
  import htg_pkg::*;

  logic valid;
  logic ready;
  ext_t tile_offset;
  ext_t tile_length;
  logic bad_tiling;

  modport source (output valid, tile_offset, tile_length, bad_tiling, input ready);
  modport sink (input valid, tile_offset, tile_length, bad_tiling, output ready);
endinterface

// ===== rtl/core/hierarchical_tile_geometry.sv =====
// ----------------------------------------------------------------------------
// hierarchical_tile_geometry
// Leaf tile offset and length of one array dimension over nested tilings.
// ----------------------------------------------------------------------------
// in_ch carries a dimension extent with a tile count and index per level;
// out_ch returns the leaf tile offset, its length and a bad_tiling flag.
// cfg_we/cfg_wdata set the number of levels applied (0 acts as 1).
// Each level is one multiply stage, a restoring divider with one stage per
// quotient bit (31) and a finalize stage: 33 stages per level.
// Throughput is one transfer per cycle while out_ch accepts; valid bits travel with the data.
// When out_ch stalls the whole pipeline holds and in_ch.ready drops,
// though bubbles still fill while the output stage is empty.
// Synchronous reset empties the pipeline and sets the level count to 1.
// Levels that are not applied are passed through untouched.
// ----------------------------------------------------------------------------
module hierarchical_tile_geometry #(
  parameter int LEVELS = htg_pkg::LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  htg_in_if.sink     in_ch,
  htg_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import htg_pkg::*;

  localparam int HW_LEVELS = (LEVELS < FIELD_LEVELS) ? LEVELS : FIELD_LEVELS;
  localparam int TOTAL     = HW_LEVELS * LVL_STAGES;

  logic [1:0] lvl_cfg_r;
  logic [1:0] used_nxt;
  logic       adv;
  logic       v_r [0:TOTAL];
  pipe_t      p_r [0:TOTAL];
  pipe_t      p_in;

  function automatic pipe_t step(input pipe_t p, input int k, input int lv);
    pipe_t         q;
    logic          live;
    cnt_t          c;
    cnt_t          ix;
    logic [PROD_W:0] pa;
    logic [PROD_W:0] pb;
    logic [CNT_W:0]  ra;
    logic [CNT_W:0]  rb;
    q    = p;
    c    = p.cnt[lv[1:0]];
    ix   = p.idx[lv[1:0]];
    live = !p.bad && ({30'd0, p.used} > lv[31:0]);
    if (live) begin
      if (k == 0) begin
        if (c == '0 || ix >= c) begin
          q.bad = 1'b1;
        end else begin
          pa = (PROD_W+1)'({15'd0, ix} * {17'd0, p.cur});
          pb = (PROD_W+1)'({15'd0, {1'b0, ix} + 17'd1} * {16'd0, p.cur});
          // quotient fits in 31 bits, so the top bits start as remainder
          q.rem_a = pa[PROD_W-1:EXT_W];
          q.dvd_a = pa[EXT_W-1:0];
          q.rem_b = pb[PROD_W-1:EXT_W];
          q.dvd_b = pb[EXT_W-1:0];
          q.quo_a = '0;
          q.quo_b = '0;
        end
      end else if (k == LVL_STAGES - 1) begin
        if (p.quo_b <= p.quo_a) begin
          q.bad = 1'b1;
        end else begin
          q.offset = p.offset + p.quo_a;
          q.cur    = p.quo_b - p.quo_a;
        end
      end else begin
        ra = {p.rem_a, p.dvd_a[EXT_W-1]};
        rb = {p.rem_b, p.dvd_b[EXT_W-1]};
        q.dvd_a = {p.dvd_a[EXT_W-2:0], 1'b0};
        q.dvd_b = {p.dvd_b[EXT_W-2:0], 1'b0};
        if (ra >= {1'b0, c}) begin
          ra = ra - {1'b0, c};
          q.quo_a = {p.quo_a[EXT_W-2:0], 1'b1};
        end else begin
          q.quo_a = {p.quo_a[EXT_W-2:0], 1'b0};
        end
        if (rb >= {1'b0, c}) begin
          rb = rb - {1'b0, c};
          q.quo_b = {p.quo_b[EXT_W-2:0], 1'b1};
        end else begin
          q.quo_b = {p.quo_b[EXT_W-2:0], 1'b0};
        end
        q.rem_a = ra[CNT_W-1:0];
        q.rem_b = rb[CNT_W-1:0];
      end
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_cfg_r <= 2'd1;
    end else if (cfg_we) begin
      lvl_cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    used_nxt = (lvl_cfg_r == 2'd0) ? 2'd1 : lvl_cfg_r;
    if ({30'd0, used_nxt} > HW_LEVELS[31:0]) begin
      used_nxt = HW_LEVELS[1:0];
    end
  end

  assign adv         = !v_r[TOTAL] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    p_in        = '0;
    p_in.used   = used_nxt;
    p_in.cur    = in_ch.extent;
    p_in.cnt[0] = in_ch.tiles_level0;
    p_in.cnt[1] = in_ch.tiles_level1;
    p_in.cnt[2] = in_ch.tiles_level2;
    p_in.idx[0] = in_ch.index_level0;
    p_in.idx[1] = in_ch.index_level1;
    p_in.idx[2] = in_ch.index_level2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= p_in;
    end
  end

  for (genvar s = 0; s < TOTAL; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_r[s+1] <= step(p_r[s], s % LVL_STAGES, s / LVL_STAGES);
      end
    end
  end

  assign out_ch.valid       = v_r[TOTAL];
  assign out_ch.bad_tiling  = p_r[TOTAL].bad;
  assign out_ch.tile_offset = p_r[TOTAL].bad ? '0 : p_r[TOTAL].offset;
  assign out_ch.tile_length = p_r[TOTAL].bad ? '0 : p_r[TOTAL].cur;

endmodule
